FILE: hw/rtl/dsj_pkg.sv
// Shared constants, control word layout and helper functions for the damper
// scattering junction. No dependencies; every other RTL file imports this.
`default_nettype none

package dsj_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int CW          = FRAC_BITS + 1;      // coefficient, 0..ONE
    localparam int DW          = FRAC_BITS + 2;      // signed distance / divider width
    localparam int SW          = SAMPLE_BITS + 1;    // wave sum
    localparam int XW          = SAMPLE_BITS + 3;    // difference before saturation
    localparam int PW          = CW + SW;            // multiplier product
    localparam int EPS_W       = FRAC_BITS;
    localparam int CNT_W       = $clog2(FRAC_BITS);
    localparam int STEP_W      = 4;

    localparam logic [CW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CW;

    localparam logic [CFG_IDX_W-1:0] CFG_ENGAGE_COEFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_COEFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_TARGET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_EPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_BYPASS  = 3'd4;

    localparam logic [CW-1:0]    ENGAGE_COEFF_RST = 17'd272;
    localparam logic [CW-1:0]    LOSS_COEFF_RST   = 17'd272;
    localparam logic [CW-1:0]    LOSS_TARGET_RST  = 17'd0;
    localparam logic [EPS_W-1:0] SETTLE_EPS_RST   = 16'd1;

    // Damper commands
    localparam logic [1:0] REQ_HOLD    = 2'd0;
    localparam logic [1:0] REQ_ENGAGE  = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    // Multiplier operand selection
    localparam logic [1:0] MUL_SCALE  = 2'd0;   // engagement * loss depth
    localparam logic [1:0] MUL_COMMON = 2'd1;   // g * |sum|
    localparam logic [1:0] MUL_ENGAGE = 2'd2;   // engage coeff * |distance|
    localparam logic [1:0] MUL_DEPTH  = 2'd3;   // loss coeff * |distance|

    // Jump conditions: when the condition holds the sequencer jumps,
    // otherwise it falls through to the next step.
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_NO_INPUT = 3'd2;
    localparam logic [2:0] COND_OUT_FULL = 3'd3;
    localparam logic [2:0] COND_LOOP     = 3'd4;

    typedef struct packed {
        logic              in_rdy;
        logic              sum_load;
        logic              mul_en;
        logic [1:0]        mul_sel;
        logic              div_load;
        logic              div_step;
        logic              out_load;
        logic              eng_upd;
        logic              dep_upd;
        logic [2:0]        cond;
        logic [STEP_W-1:0] jmp_tgt;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic out_full;
        logic loop_done;
    } t_cond;

    function automatic logic [CW-1:0] cap_one(input logic [CW-1:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] saturate(input logic signed [XW-1:0] v);
        logic [XW-SAMPLE_BITS:0] hi_bits;
        hi_bits = v[XW-1:SAMPLE_BITS-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return v[SAMPLE_BITS-1:0];
        end else if (v[XW-1]) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dsj_if.sv
// Channel interfaces of the damper scattering junction: input words, result
// words and configuration writes. Depends on dsj_pkg.
`default_nettype none

interface dsj_in_if import dsj_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] from_nut;
    logic signed [SAMPLE_BITS-1:0] from_bridge;
    logic [1:0]                    req_type;

    modport source(output valid, output from_nut, output from_bridge, output req_type,
                   input ready);
    modport sink(input valid, input from_nut, input from_bridge, input req_type,
                 output ready);
endinterface

interface dsj_out_if import dsj_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] to_bridge;
    logic signed [SAMPLE_BITS-1:0] to_nut;

    modport source(output valid, output to_bridge, output to_nut, input ready);
    modport sink(input valid, input to_bridge, input to_nut, output ready);
endinterface

interface dsj_cfg_if import dsj_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dsj_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on dsj_pkg for the control word and condition layouts.
`default_nettype none

module dsj_seq import dsj_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_cond i_cond,
    output t_ctrl      o_ctrl
);

    localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL_S    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DIV_LOAD = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIV_ITER = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_C    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MUL_E    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_UPD_E    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MUL_D    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_UPD_D    = 4'd9;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              jump;

    function automatic t_ctrl program_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '0;
        unique case (step)
            STEP_WAIT: begin
                w.in_rdy  = 1'b1;
                w.cond    = COND_NO_INPUT;
                w.jmp_tgt = STEP_WAIT;
            end
            STEP_MUL_S: begin
                w.sum_load = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_sel  = MUL_SCALE;
            end
            STEP_DIV_LOAD: begin
                w.div_load = 1'b1;
            end
            STEP_DIV_ITER: begin
                w.div_step = 1'b1;
                w.cond     = COND_LOOP;
                w.jmp_tgt  = STEP_DIV_ITER;
            end
            STEP_MUL_C: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_COMMON;
            end
            STEP_EMIT: begin
                w.out_load = 1'b1;
                w.cond     = COND_OUT_FULL;
                w.jmp_tgt  = STEP_EMIT;
            end
            STEP_MUL_E: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_ENGAGE;
            end
            STEP_UPD_E: begin
                w.eng_upd = 1'b1;
            end
            STEP_MUL_D: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_DEPTH;
            end
            STEP_UPD_D: begin
                w.dep_upd = 1'b1;
                w.cond    = COND_ALWAYS;
                w.jmp_tgt = STEP_WAIT;
            end
            default: begin
                w.cond    = COND_ALWAYS;
                w.jmp_tgt = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    assign o_ctrl = program_word(r_step);

    always_comb begin
        unique case (o_ctrl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !i_cond.in_fire;
            COND_OUT_FULL: jump = i_cond.out_full;
            COND_LOOP:     jump = !i_cond.loop_done;
            default:       jump = 1'b1;
        endcase
        n_step = jump ? o_ctrl.jmp_tgt : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/damper_scattering_junction.sv
// Top level of the damper scattering junction: configuration registers,
// datapath and output register, run by dsj_seq. Depends on dsj_pkg, dsj_if.
//
// A result word is registered at the emit step, after the 16-iteration
// restoring divider for the common-term gain; the next word is taken once the
// microcode program has also updated both smoothers. A stalled output holds
// the program at its emit step until the register frees.
// Reset: synchronous, active low; smoother state clears, registers take their
// default values, any pending result is dropped.
`default_nettype none

module damper_scattering_junction import dsj_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    dsj_in_if.sink    i_in,
    dsj_out_if.source o_out,
    dsj_cfg_if.sink   i_cfg
);

    t_ctrl ctrl;
    t_cond cond;

    // Configuration
    logic [CW-1:0]    r_engage_coeff;
    logic [CW-1:0]    r_loss_coeff;
    logic [CW-1:0]    r_loss_target;
    logic [EPS_W-1:0] r_settle_eps;
    logic             r_loss_bypass;

    // Smoother state
    logic [CW-1:0] r_eng;
    logic          r_tgt;
    logic [CW-1:0] r_depth;
    logic [CW-1:0] n_eng;
    logic [CW-1:0] n_depth;

    // Working registers
    logic signed [SAMPLE_BITS-1:0] r_nut;
    logic signed [SAMPLE_BITS-1:0] r_bridge;
    logic                          r_sum_neg;
    logic [SW-1:0]                 r_sum_mag;
    logic [PW-1:0]                 r_prod;
    logic [DW-1:0]                 r_rem;
    logic [DW-1:0]                 r_div;
    logic [FRAC_BITS-1:0]          r_quot;
    logic [CNT_W-1:0]              r_cnt;

    // Output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_to_bridge;
    logic signed [SAMPLE_BITS-1:0] r_to_nut;

    logic in_fire;
    logic out_full;
    logic out_load_fire;

    logic signed [SW-1:0] sum_c;
    logic [CW-1:0]        mul_a;
    logic [SW-1:0]        mul_b;
    logic [CW-1:0]        s_c;
    logic [DW:0]          rem2;
    logic [SW-1:0]        q_c;
    logic signed [SW:0]   common;
    logic signed [XW-1:0] diff_nut;
    logic signed [XW-1:0] diff_bridge;
    logic [CW-1:0]        step_c;

    logic [CW-1:0]        tgt_e;
    logic signed [DW-1:0] dist_e;
    logic [DW-1:0]        abs_e;
    logic [CW-1:0]        mag_e;
    logic [CW-1:0]        tgt_d;
    logic signed [DW-1:0] dist_d;
    logic [DW-1:0]        abs_d;
    logic [CW-1:0]        mag_d;

    dsj_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl)
    );

    // Handshakes
    assign i_in.ready    = ctrl.in_rdy;
    assign in_fire       = ctrl.in_rdy && i_in.valid;
    assign out_full      = r_out_valid && !o_out.ready;
    assign out_load_fire = ctrl.out_load && !out_full;
    assign i_cfg.ready   = 1'b1;

    assign cond.in_fire   = in_fire;
    assign cond.out_full  = out_full;
    assign cond.loop_done = (r_cnt == CNT_W'(FRAC_BITS - 1));

    assign o_out.valid     = r_out_valid;
    assign o_out.to_bridge = r_to_bridge;
    assign o_out.to_nut    = r_to_nut;

    // Wave sum and the common term
    assign sum_c       = SW'(r_nut) + SW'(r_bridge);
    assign q_c         = r_prod[FRAC_BITS +: SW];
    assign common      = r_sum_neg ? -signed'({1'b0, q_c}) : signed'({1'b0, q_c});
    assign diff_nut    = XW'(r_nut) - XW'(common);
    assign diff_bridge = XW'(r_bridge) - XW'(common);

    // Divider: the top quotient bits of s*ONE/(s+ONE) are zero, so the
    // remainder starts at s and only the fraction bits are iterated.
    assign s_c  = r_prod[FRAC_BITS +: CW];
    assign rem2 = {r_rem, 1'b0};

    // Smoother distances
    assign step_c = r_prod[FRAC_BITS +: CW];
    assign tgt_e  = r_tgt ? ONE_Q : '0;
    assign dist_e = signed'({1'b0, tgt_e}) - signed'({1'b0, r_eng});
    assign abs_e  = dist_e[DW-1] ? DW'(-dist_e) : DW'(dist_e);
    assign mag_e  = abs_e[CW-1:0];
    assign tgt_d  = cap_one(r_loss_target);
    assign dist_d = signed'({1'b0, tgt_d}) - signed'({1'b0, r_depth});
    assign abs_d  = dist_d[DW-1] ? DW'(-dist_d) : DW'(dist_d);
    assign mag_d  = abs_d[CW-1:0];

    always_comb begin
        if (mag_e < {1'b0, r_settle_eps}) begin
            n_eng = tgt_e;
        end else if (dist_e[DW-1]) begin
            n_eng = r_eng - step_c;
        end else begin
            n_eng = r_eng + step_c;
        end
        if (mag_d < {1'b0, r_settle_eps}) begin
            n_depth = tgt_d;
        end else if (dist_d[DW-1]) begin
            n_depth = r_depth - step_c;
        end else begin
            n_depth = r_depth + step_c;
        end
    end

    // Shared multiplier operands
    always_comb begin
        unique case (ctrl.mul_sel)
            MUL_SCALE: begin
                mul_a = r_eng;
                mul_b = SW'(r_depth);
            end
            MUL_COMMON: begin
                mul_a = r_loss_bypass ? '0 : CW'(r_quot);
                mul_b = r_sum_mag;
            end
            MUL_ENGAGE: begin
                mul_a = cap_one(r_engage_coeff);
                mul_b = SW'(mag_e);
            end
            MUL_DEPTH: begin
                mul_a = cap_one(r_loss_coeff);
                mul_b = SW'(mag_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control state, configuration and smoothers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engage_coeff <= ENGAGE_COEFF_RST;
            r_loss_coeff   <= LOSS_COEFF_RST;
            r_loss_target  <= LOSS_TARGET_RST;
            r_settle_eps   <= SETTLE_EPS_RST;
            r_loss_bypass  <= 1'b0;
            r_eng          <= '0;
            r_tgt          <= 1'b0;
            r_depth        <= cap_one(LOSS_TARGET_RST);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ENGAGE_COEFF: r_engage_coeff <= i_cfg.data;
                    CFG_LOSS_COEFF:   r_loss_coeff   <= i_cfg.data;
                    CFG_LOSS_TARGET:  r_loss_target  <= i_cfg.data;
                    CFG_SETTLE_EPS:   r_settle_eps   <= i_cfg.data[EPS_W-1:0];
                    CFG_LOSS_BYPASS:  r_loss_bypass  <= i_cfg.data[0];
                    default: ;
                endcase
            end
            // The command lands on the target now, but the smoother only
            // moves after this word's output has been formed.
            if (in_fire) begin
                unique case (i_in.req_type)
                    REQ_ENGAGE:  r_tgt <= 1'b1;
                    REQ_RELEASE: r_tgt <= 1'b0;
                    default: ;
                endcase
            end
            if (ctrl.eng_upd) begin
                r_eng <= n_eng;
            end
            if (ctrl.dep_upd) begin
                r_depth <= n_depth;
            end
            if (out_load_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_nut    <= i_in.from_nut;
            r_bridge <= i_in.from_bridge;
        end
        if (ctrl.sum_load) begin
            r_sum_neg <= sum_c[SW-1];
            r_sum_mag <= sum_c[SW-1] ? SW'(-sum_c) : SW'(sum_c);
        end
        if (ctrl.mul_en) begin
            r_prod <= PW'(mul_a) * PW'(mul_b);
        end
        if (ctrl.div_load) begin
            r_rem  <= DW'(s_c);
            r_div  <= DW'(s_c) + DW'(ONE_Q);
            r_quot <= '0;
            r_cnt  <= '0;
        end else if (ctrl.div_step) begin
            if (rem2 >= {1'b0, r_div}) begin
                r_rem  <= DW'(rem2 - {1'b0, r_div});
                r_quot <= {r_quot[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem2[DW-1:0];
                r_quot <= {r_quot[FRAC_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (out_load_fire) begin
            r_to_bridge <= saturate(diff_nut);
            r_to_nut    <= saturate(diff_bridge);
        end
    end

    // A waiting result word is never overwritten.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !out_load_fire)
        else $error("result word overwritten while waiting");

    // Restoring division keeps the remainder below the divisor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.div_step |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    // Smoothers never overshoot, so both stay within zero to one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eng <= ONE_Q) && (r_depth <= ONE_Q))
        else $error("smoother state above one");

    // No new word is taken while the divider is running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.div_step || ctrl.div_load) |-> !i_in.ready)
        else $error("input accepted mid-computation");

endmodule

`default_nettype wire

FILE: bench/tb_damper_scattering_junction.sv
// Self-checking bench for damper_scattering_junction: a directed table, then
// random words in phases that vary idling and stalls, each result checked
// against a local model. Depends on dsj_pkg and the channel interfaces in dsj_if.
module tb_damper_scattering_junction;
    import dsj_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 4;
    localparam longint UNITY = 64'sd1 << FRAC_BITS;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic signed [SAMPLE_BITS-1:0] MAX_WAVE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIN_WAVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 66;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] to_bridge;
        logic [SAMPLE_BITS-1:0] to_nut;
    } t_wave_pair;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_BITS-1:0] nut;
        logic [SAMPLE_BITS-1:0] bridge;
        logic [1:0]             req;
        bit                     copies;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dsj_in_if  in_if();
    dsj_out_if out_if();
    dsj_cfg_if cfg_if();

    damper_scattering_junction i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Local copy of the junction state and its registers.
    longint engagement_q16, engage_goal, depth_q16;
    longint engage_k, loss_k, depth_goal, snap_dist;
    bit     pass_through;

    t_wave_pair wave_q[$];
    t_plan_row  plan[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic longint clamp_one(longint v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // Product scaled by ONE, truncated toward zero.
    function automatic longint scale_q16(longint k, longint x);
        longint mag, q;
        mag = (x < 0) ? -x : x;
        q = (k * mag) >>> FRAC_BITS;
        return (x < 0) ? -q : q;
    endfunction

    function automatic longint glide(longint value, longint target, longint k);
        longint gap, mag;
        gap = target - value;
        mag = (gap < 0) ? -gap : gap;
        if (mag < snap_dist) return target;
        return value + scale_q16(k, gap);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clip(longint v);
        if (v > longint'(MAX_WAVE)) return MAX_WAVE;
        if (v < longint'(MIN_WAVE)) return MIN_WAVE;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // One sample through the junction: output first, then both smoothers.
    function automatic t_wave_pair junction_step(logic signed [SAMPLE_BITS-1:0] nut,
                                                 logic signed [SAMPLE_BITS-1:0] bridge,
                                                 logic [1:0] req);
        longint s, g, common, sum;
        t_wave_pair r;
        if (req == REQ_ENGAGE) begin
            engage_goal = UNITY;
        end else if (req == REQ_RELEASE) begin
            engage_goal = 0;
        end
        g = 0;
        if (!pass_through) begin
            s = (engagement_q16 * depth_q16) >>> FRAC_BITS;
            g = (s <<< FRAC_BITS) / (s + UNITY);
        end
        sum = longint'(nut) + longint'(bridge);
        common = scale_q16(g, sum);
        r.to_bridge = clip(longint'(nut) - common);
        r.to_nut = clip(longint'(bridge) - common);
        engagement_q16 = glide(engagement_q16, engage_goal, clamp_one(engage_k));
        depth_q16 = glide(depth_q16, clamp_one(depth_goal), clamp_one(loss_k));
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENGAGE_COEFF: engage_k = data;
            CFG_LOSS_COEFF:   loss_k = data;
            CFG_LOSS_TARGET:  depth_goal = data;
            CFG_SETTLE_EPS:   snap_dist = data[EPS_W-1:0];
            CFG_LOSS_BYPASS:  pass_through = data[0];
            default: ;
        endcase
    endfunction

    function automatic t_plan_row word_row(logic [SAMPLE_BITS-1:0] nut,
                                           logic [SAMPLE_BITS-1:0] bridge,
                                           logic [1:0] req, bit copies);
        t_plan_row r;
        r.kind = ROW_WORD;
        r.idx = CFG_ENGAGE_COEFF;
        r.data = '0;
        r.nut = nut;
        r.bridge = bridge;
        r.req = req;
        r.copies = copies;
        return r;
    endfunction

    function automatic t_plan_row reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r = word_row('0, '0, REQ_HOLD, 1'b0);
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_wave();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return MAX_WAVE;
            1: return MIN_WAVE;
            2: return SAMPLE_BITS'($urandom_range(2047)) - SAMPLE_BITS'(1024);
            default: return r[SAMPLE_BITS-1:0];
        endcase
    endfunction

    function automatic logic [1:0] pick_req();
        int k;
        k = $urandom_range(99);
        if (k < 70) return REQ_HOLD;
        if (k < 82) return REQ_ENGAGE;
        if (k < 94) return REQ_RELEASE;
        return REQ_UNUSED;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        case ($urandom_range(5))
            0: return CFG_DATA_W'($urandom_range(300));
            1: return CFG_DATA_W'($urandom_range(131071, 65537));
            default: return CFG_DATA_W'($urandom_range(65536, 1000));
        endcase
    endfunction

    // Present one word, possibly after idle cycles, and record what it should give.
    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] nut,
                             input logic signed [SAMPLE_BITS-1:0] bridge,
                             input logic [1:0] req, input bit copies);
        t_wave_pair p;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.from_nut <= nut;
        in_if.from_bridge <= bridge;
        in_if.req_type <= req;
        do @(posedge i_clk); while (!in_if.ready);
        p = junction_step(nut, bridge, req);
        if (copies) begin
            p.to_bridge = nut;
            p.to_nut = bridge;
        end
        wave_q.push_back(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg(idx, data);
    endtask

    // The smoothers still run after the last result leaves, so the junction
    // is only idle once it is back at its input step.
    task automatic drain();
        while (wave_q.size() != 0 || !in_if.ready) @(posedge i_clk);
    endtask

    task automatic check_field(input string label, input logic [SAMPLE_BITS-1:0] want,
                               input logic [SAMPLE_BITS-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10) begin
                $display("%s mismatch: expected %0d, got %0d", label, $signed(want),
                         $signed(got));
            end
        end
    endtask

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_wave_pair want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (wave_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result word: to_bridge %0d, to_nut %0d",
                             out_if.to_bridge, out_if.to_nut);
                end
            end else begin
                want = wave_q.pop_front();
                check_field("to_bridge", want.to_bridge, out_if.to_bridge);
                check_field("to_nut", want.to_nut, out_if.to_nut);
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_damper_scattering_junction: errors");
        $finish;
    end

    initial begin
        int ph;
        logic [CFG_DATA_W-1:0] ek, lk, lt, se, bp;

        engage_k = ENGAGE_COEFF_RST;
        loss_k = LOSS_COEFF_RST;
        depth_goal = LOSS_TARGET_RST;
        snap_dist = SETTLE_EPS_RST;
        pass_through = 1'b0;
        engagement_q16 = 0;
        engage_goal = 0;
        depth_q16 = clamp_one(depth_goal);

        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.from_nut <= '0;
        in_if.from_bridge <= '0;
        in_if.req_type <= REQ_HOLD;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_ENGAGE_COEFF;
        cfg_if.data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With no loss depth after reset every word passes straight through,
        // including the one that carries the engage command.
        plan.push_back(word_row(MAX_WAVE, MIN_WAVE, REQ_HOLD, 1'b1));
        plan.push_back(word_row(MIN_WAVE, MAX_WAVE, REQ_ENGAGE, 1'b1));
        plan.push_back(word_row('0, '0, REQ_UNUSED, 1'b1));
        plan.push_back(word_row(-24'sd1, 24'sd1, REQ_HOLD, 1'b1));
        plan.push_back(word_row(MAX_WAVE, MAX_WAVE, REQ_RELEASE, 1'b1));
        plan.push_back(word_row(MIN_WAVE, MIN_WAVE, REQ_HOLD, 1'b1));
        // Oversized registers act as one; no snapping.
        plan.push_back(reg_row(CFG_ENGAGE_COEFF, 17'h1FFFF));
        plan.push_back(reg_row(CFG_LOSS_COEFF, 17'h1FFFF));
        plan.push_back(reg_row(CFG_LOSS_TARGET, 17'h1FFFF));
        plan.push_back(reg_row(CFG_SETTLE_EPS, '0));
        plan.push_back(word_row(24'sd4000000, -24'sd1234567, REQ_ENGAGE, 1'b0));
        plan.push_back(word_row(MAX_WAVE, MAX_WAVE, REQ_HOLD, 1'b0));
        plan.push_back(word_row(MIN_WAVE, MIN_WAVE, REQ_HOLD, 1'b0));
        plan.push_back(word_row(MAX_WAVE, MIN_WAVE, REQ_HOLD, 1'b0));
        plan.push_back(word_row(MIN_WAVE, MAX_WAVE, REQ_UNUSED, 1'b0));
        plan.push_back(word_row(24'sd1193046, -24'sd6636321, REQ_RELEASE, 1'b0));
        plan.push_back(word_row(MAX_WAVE, '0, REQ_HOLD, 1'b0));
        // Widest snap distance with the slowest smoother.
        plan.push_back(reg_row(CFG_SETTLE_EPS, 17'h1FFFF));
        plan.push_back(reg_row(CFG_ENGAGE_COEFF, 17'd1));
        plan.push_back(word_row(MIN_WAVE, '0, REQ_ENGAGE, 1'b0));
        plan.push_back(word_row(24'sd12345, -24'sd54321, REQ_HOLD, 1'b0));
        // Bypass gives exact copies whatever the smoother state.
        plan.push_back(reg_row(CFG_LOSS_BYPASS, 17'd1));
        plan.push_back(reg_row(CFG_UNUSED, 17'h1FFFF));
        plan.push_back(word_row(MAX_WAVE, MAX_WAVE, REQ_ENGAGE, 1'b1));
        plan.push_back(word_row(MIN_WAVE, MIN_WAVE, REQ_RELEASE, 1'b1));
        plan.push_back(word_row(24'sh2AAAAA, 24'sh555555, REQ_HOLD, 1'b1));
        // A coefficient just under one with no snapping leaves both smoothers
        // stuck one LSB short of their targets.
        plan.push_back(reg_row(CFG_LOSS_BYPASS, '0));
        plan.push_back(reg_row(CFG_SETTLE_EPS, '0));
        plan.push_back(reg_row(CFG_ENGAGE_COEFF, 17'd65535));
        plan.push_back(reg_row(CFG_LOSS_COEFF, 17'd65535));
        plan.push_back(reg_row(CFG_LOSS_TARGET, 17'd30000));
        plan.push_back(word_row(24'sd3000000, 24'sd2000000, REQ_ENGAGE, 1'b0));
        plan.push_back(word_row(24'sd3000000, 24'sd2000000, REQ_HOLD, 1'b0));
        plan.push_back(word_row(-24'sd3000000, 24'sd1000000, REQ_HOLD, 1'b0));
        plan.push_back(word_row(MAX_WAVE, MAX_WAVE, REQ_HOLD, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                in_if.valid <= 1'b0;
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                cfg_if.valid <= 1'b0;
                send_word(plan[i].nut, plan[i].bridge, plan[i].req, plan[i].copies);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            in_if.valid <= 1'b0;
            drain();
            if (ph == 1) begin
                ek = 17'h1FFFF;
                lk = 17'h1FFFF;
                lt = 17'h1FFFF;
                se = '0;
                bp = '0;
            end else if (ph == 2) begin
                ek = '0;
                lk = '0;
                lt = '0;
                se = 17'h0FFFF;
                bp = 17'h1FFFE;
            end else begin
                ek = pick_coeff();
                lk = pick_coeff();
                case ($urandom_range(3))
                    0: lt = 17'(UNITY);
                    1: lt = 17'($urandom_range(131071, 65537));
                    default: lt = 17'($urandom_range(65536));
                endcase
                case ($urandom_range(4))
                    0: se = '0;
                    1: se = 17'($urandom_range(131071));
                    default: se = 17'($urandom_range(64));
                endcase
                bp = {16'($urandom_range(65535)), $urandom_range(4) == 0};
            end
            write_reg(CFG_ENGAGE_COEFF, ek);
            write_reg(CFG_LOSS_COEFF, lk);
            write_reg(CFG_LOSS_TARGET, lt);
            write_reg(CFG_SETTLE_EPS, se);
            write_reg(CFG_LOSS_BYPASS, bp);
            cfg_if.valid <= 1'b0;

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase

            repeat (WORDS_PER_PHASE) send_word(pick_wave(), pick_wave(), pick_req(), 1'b0);
        end

        in_if.valid <= 1'b0;
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && wave_q.size() == 0) begin
            $display("tb_damper_scattering_junction: clean");
        end else begin
            $display("tb_damper_scattering_junction: errors");
        end
        $finish;
    end

endmodule
